@@ design/assert_macros.svh @@
// ============================================================================
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BSQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define BSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bsqosc_pkg.sv @@
// ============================================================================
// bsqosc_pkg
// Shared types and fixed constants of the square-wave wavetable oscillator.
// ============================================================================
package bsqosc_pkg;

    localparam int FREQ_W   = 24;
    localparam int STEP_W   = 24;
    localparam int PHASE_W  = 32;
    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 16;

    typedef logic signed [FREQ_W-1:0]   freq_t;
    typedef logic        [STEP_W-1:0]   step_t;
    typedef logic        [PHASE_W-1:0]  phase_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [FRAC_W-1:0]   frac_t;

    // Increment per Hz after reset: 2^32 / 48000.
    localparam step_t STEP_RESET = 24'd89478;

    // Sine evaluation constants, Q30.
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

endpackage

@@ design/bsqosc_in_if.sv @@
// ============================================================================
// bsqosc_in_if
// Input channel: one frequency word with an optional phase load.
// ============================================================================
interface bsqosc_in_if;

    logic                   valid;
    logic                   ready;
    bsqosc_pkg::freq_t      freq_q8;
    logic                   load_phase;
    bsqosc_pkg::phase_t     new_phase;

    modport source
    (
        output valid,
        input  ready,
        output freq_q8,
        output load_phase,
        output new_phase
    );

    modport sink
    (
        input  valid,
        output ready,
        input  freq_q8,
        input  load_phase,
        input  new_phase
    );

endinterface

@@ design/bsqosc_out_if.sv @@
// ============================================================================
// bsqosc_out_if
// Output channel: one audio sample word.
// ============================================================================
interface bsqosc_out_if;

    logic                   valid;
    logic                   ready;
    bsqosc_pkg::sample_t    sample;

    modport source
    (
        output valid,
        input  ready,
        output sample
    );

    modport sink
    (
        input  valid,
        output ready,
        input  sample
    );

endinterface

@@ design/bsqosc_rom.sv @@
// ============================================================================
// bsqosc_rom
// Band-limited square wave table, built at elaboration, two registered ports.
// ============================================================================
module bsqosc_rom #(
    parameter int TABLE_LEN = 1024,
    parameter int HARMONICS = 16
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [$clog2(TABLE_LEN)-1:0]  addr_a,
    input  logic [$clog2(TABLE_LEN)-1:0]  addr_b,
    output bsqosc_pkg::sample_t           data_a,
    output bsqosc_pkg::sample_t           data_b
);

    typedef bsqosc_pkg::sample_t rom_t [TABLE_LEN];

    localparam longint unsigned TABLE_LEN_U = 64'(TABLE_LEN);

    // Signed quotient truncated toward zero, by shift and subtract.
    function automatic longint div_trunc(longint num, longint unsigned den);
        longint unsigned mag;
        longint unsigned quo;
        longint unsigned rem;
        mag = (num < 0) ? $unsigned(-num) : $unsigned(num);
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], mag[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return (num < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    // Quarter-wave folded sine in Q30, Horner series.
    function automatic longint sine_q30(longint unsigned a);
        longint unsigned t;
        longint unsigned quad;
        longint unsigned x;
        longint unsigned th;
        longint unsigned th2;
        longint unsigned r;
        t    = (a << 32) / TABLE_LEN_U;
        quad = (t >> 30) & 64'd3;
        x    = t & (bsqosc_pkg::Q30_ONE - 64'd1);
        if (quad[0])
        begin
            x = bsqosc_pkg::Q30_ONE - x;
        end
        th  = (x * bsqosc_pkg::HALF_PI_Q30) >> 30;
        th2 = (th * th) >> 30;
        r   = bsqosc_pkg::Q30_ONE - th2 / 64'd110;
        r   = bsqosc_pkg::Q30_ONE - ((th2 * r) >> 30) / 64'd72;
        r   = bsqosc_pkg::Q30_ONE - ((th2 * r) >> 30) / 64'd42;
        r   = bsqosc_pkg::Q30_ONE - ((th2 * r) >> 30) / 64'd20;
        r   = bsqosc_pkg::Q30_ONE - ((th2 * r) >> 30) / 64'd6;
        r   = (th * r) >> 30;
        return (quad >= 64'd2) ? -longint'(r) : longint'(r);
    endfunction

    // Sum odd harmonics sin(k*x)/k, round to Q15, saturate.
    function automatic rom_t build_rom();
        rom_t   rom;
        longint acc;
        longint v;
        int     k;
        int     a;
        for (int i = 0; i < TABLE_LEN; i++)
        begin
            acc = 64'sd0;
            for (int j = 0; j < HARMONICS; j++)
            begin
                k   = (j * 2) + 1;
                a   = (i * k) % TABLE_LEN;
                acc = acc + div_trunc(sine_q30(64'(a)), 64'(k));
            end
            v = (acc + 64'sd16384) >>> 15;
            if (v > 64'sd32767)
            begin
                v = 64'sd32767;
            end
            if (v < -64'sd32768)
            begin
                v = -64'sd32768;
            end
            rom[i] = 16'(v);
        end
        return rom;
    endfunction

    localparam rom_t WAVE = build_rom();

    bsqosc_pkg::sample_t data_a_reg;
    bsqosc_pkg::sample_t data_b_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_a_reg <= WAVE[addr_a];
            data_b_reg <= WAVE[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

@@ design/bandlimited_square_wavetable_osc_core.sv @@
// ============================================================================
// bandlimited_square_wavetable_osc_core
// Each accepted word passes phase_reg, idx_reg, the table read, prod_reg and sample_reg.
// Throughput: one word per cycle while the output is not stalled; the phase loop closes in one add per word.
// The five-stage pipeline stalls per stage, so bubbles are squeezed out.
// Reset clears the phase, the pending increment and all valid flags, and
// sets step_per_hz to 89478. The wave table is constant and needs no fill.
// ============================================================================
module bandlimited_square_wavetable_osc_core #(
    parameter int TABLE_LEN = 1024,
    parameter int HARMONICS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    bsqosc_in_if.sink               ctrl,
    bsqosc_out_if.source            audio,
    input  logic                    cfg_we,
    input  bsqosc_pkg::step_t       cfg_wdata
);

    localparam int IDX_W  = $clog2(TABLE_LEN);
    localparam int LEN_W  = IDX_W + 1;
    localparam int P_W    = bsqosc_pkg::PHASE_W + LEN_W;
    localparam int MUL_W  = bsqosc_pkg::FREQ_W + bsqosc_pkg::STEP_W + 1;
    localparam int DIFF_W = bsqosc_pkg::SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + bsqosc_pkg::FRAC_W;

    // ------------------------------------------------------------------
    // Stage enables: a stage moves when it is empty or its successor moves.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || audio.ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign ctrl.ready = en1;

    logic accept;
    assign accept = ctrl.valid && en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= ctrl.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration: step_per_hz, to be written by the user only while the block is idle; not enforced.
    // ------------------------------------------------------------------
    bsqosc_pkg::step_t step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= bsqosc_pkg::STEP_RESET;
        end
        else if (cfg_we)
        begin
            step_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: phase accumulator. phase_reg holds the phase that the most
    // recent word sampled at; inc_reg holds that word's increment, which
    // is added only when the next word arrives. This keeps the multiply
    // out of the feedback path.
    // ------------------------------------------------------------------
    bsqosc_pkg::phase_t  phase_reg;
    bsqosc_pkg::phase_t  phase_next;
    bsqosc_pkg::phase_t  inc_reg;
    bsqosc_pkg::phase_t  inc_next;
    logic signed [MUL_W-1:0] freq_prod;

    // Signed frequency times unsigned step; drop 8 fraction bits, wrap.
    assign freq_prod = ctrl.freq_q8 * $signed({1'b0, step_reg});
    assign inc_next  = freq_prod[8 +: bsqosc_pkg::PHASE_W];

    assign phase_next = ctrl.load_phase ? ctrl.new_phase : (phase_reg + inc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            inc_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            inc_reg   <= inc_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: split phase * TABLE_LEN into index and fraction.
    // ------------------------------------------------------------------
    logic [P_W-1:0]      pos;
    logic [IDX_W-1:0]    idx;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    nxt_reg;
    bsqosc_pkg::frac_t   frac2_reg;

    assign pos = phase_reg * LEN_W'(TABLE_LEN);
    assign idx = pos[bsqosc_pkg::PHASE_W +: IDX_W];

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            idx_reg   <= idx;
            // Wrap the neighbor of the last entry back to entry 0.
            nxt_reg   <= (idx == IDX_W'(TABLE_LEN - 1)) ? '0 : idx + 1'b1;
            frac2_reg <= pos[bsqosc_pkg::PHASE_W-1 -: bsqosc_pkg::FRAC_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: table read of both neighbors.
    // ------------------------------------------------------------------
    bsqosc_pkg::sample_t ya3;
    bsqosc_pkg::sample_t yb3;
    bsqosc_pkg::frac_t   frac3_reg;

    bsqosc_rom #(
        .TABLE_LEN (TABLE_LEN),
        .HARMONICS (HARMONICS)
    ) u_rom (
        .clk    (clk),
        .rd_en  (en3),
        .addr_a (idx_reg),
        .addr_b (nxt_reg),
        .data_a (ya3),
        .data_b (yb3)
    );

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            frac3_reg <= frac2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: slope times fraction.
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W:0]     prod_full;
    logic signed [PROD_W-1:0]   prod_reg;
    bsqosc_pkg::sample_t        ya4_reg;

    assign diff      = DIFF_W'(yb3) - DIFF_W'(ya3);
    assign prod_full = diff * $signed({1'b0, frac3_reg});

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            prod_reg <= prod_full[PROD_W-1:0];
            ya4_reg  <= ya3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: add the floored step to the left entry; output register.
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] interp;
    bsqosc_pkg::sample_t      sample_reg;

    assign interp = DIFF_W'(ya4_reg) + prod_reg[PROD_W-1 -: DIFF_W];

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            sample_reg <= interp[bsqosc_pkg::SAMPLE_W-1:0];
        end
    end

    assign audio.valid  = v5_reg;
    assign audio.sample = sample_reg;

endmodule

@@ design/bsqosc_checker.sv @@
// ============================================================================
// bsqosc_checker
// Port-level checks of the oscillator core, bound into the core module.
// ============================================================================
`include "assert_macros.svh"

module bsqosc_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    bsqosc_in_if.sink               ctrl,
    bsqosc_out_if.source            audio
);

    logic       in_acc;
    logic       out_acc;
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    assign in_acc  = ctrl.valid && ctrl.ready;
    assign out_acc = audio.valid && audio.ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc)
        begin
            inflight_next = inflight_reg + 3'd1;
        end
        else if (out_acc && !in_acc)
        begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    `BSQ_ASSERT_NEXT(a_out_hold, clk, rst_n, audio.valid && !audio.ready, audio.valid, "output word dropped while stalled")
    `BSQ_ASSERT_NEXT(a_out_stable, clk, rst_n, audio.valid && !audio.ready, $stable(audio.sample), "stalled sample changed")
    `BSQ_ASSERT_SAME(a_no_invent, clk, rst_n, audio.valid, inflight_reg != 3'd0, "output word without a pending input")
    `BSQ_ASSERT_SAME(a_depth, clk, rst_n, 1'b1, inflight_reg <= 3'd5, "more words in flight than pipeline stages")
    `BSQ_ASSERT_SAME(a_empty_ready, clk, rst_n, inflight_reg == 3'd0, ctrl.ready, "empty core refuses input")

endmodule

bind bandlimited_square_wavetable_osc_core bsqosc_checker u_bsqosc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .audio     (audio)
);
